// ----- hdl/smap_pkg.sv -----
// shared types and constants for the serial bank switch mapper
package smap_pkg;

    // address window sizes of the switchable banks
    localparam int PRG_WINDOW_BITS = 14;
    localparam int CHR_WINDOW_BITS = 12;

    // field widths
    localparam int ADDR_W  = 16;
    localparam int DATA_W  = 8;
    localparam int PHYS_W  = 19;
    localparam int BANK_W  = 5;
    localparam int CFG_W   = 5;

    // serial load register markers and defaults
    localparam logic [BANK_W-1:0] SHIFT_EMPTY       = 5'h10;
    localparam logic [1:0]        PRG_MODE_FIX_LAST = 2'd3;
    localparam logic [3:0]        LAST_BANK_LOW     = 4'hF;
    localparam logic [DATA_W-1:0] OPEN_PPU          = 8'hFF;
    localparam logic [DATA_W-1:0] OPEN_CPU          = 8'h00;

    // nametable mirroring codes
    localparam logic [1:0] MIR_HEADER = 2'd0;
    localparam logic [1:0] MIR_VERT   = 2'd1;
    localparam logic [1:0] MIR_HORZ   = 2'd2;

    // control register mirroring field codes
    localparam logic [1:0] CTL_MIR_VERT = 2'd2;
    localparam logic [1:0] CTL_MIR_HORZ = 2'd3;

    // prg banking modes
    localparam logic [1:0] PRG_MODE_32K_A = 2'd0;
    localparam logic [1:0] PRG_MODE_32K_B = 2'd1;
    localparam logic [1:0] PRG_MODE_FIX_0 = 2'd2;

    typedef enum logic [1:0] {
        OP_CPU_RD,
        OP_CPU_WR,
        OP_PPU_RD,
        OP_PPU_WR
    } t_opcode;

    typedef enum logic [2:0] {
        TGT_NONE,
        TGT_PRG_ROM,
        TGT_PRG_RAM,
        TGT_CHR_ROM,
        TGT_CHR_RAM
    } t_target;

    typedef enum logic [1:0] {
        BOARD_GENERIC,
        BOARD_BIG_CHR,
        BOARD_RAM_OFF,
        BOARD_OUTER_PRG
    } t_board;

    typedef enum logic [1:0] {
        CFG_BOARD_KIND,
        CFG_PRG_MASK,
        CFG_CHR_MASK,
        CFG_CHR_IS_RAM
    } t_cfg_idx;

    // destination of a completed serial load, from address bits 14..13
    typedef enum logic [1:0] {
        SEL_CONTROL,
        SEL_CHR0,
        SEL_CHR1,
        SEL_PRG
    } t_load_sel;

    typedef struct packed {
        t_opcode             opcode;
        logic [ADDR_W-1:0]   address;
        logic [DATA_W-1:0]   data;
    } t_item;

    typedef struct packed {
        t_board              board;
        logic [BANK_W-1:0]   prg_mask;
        logic [BANK_W-1:0]   chr_mask;
        logic                chr_is_ram;
    } t_map_cfg;

    typedef struct packed {
        logic [BANK_W-1:0]   shift;
        logic [1:0]          prg_mode;
        logic                chr_mode;
        logic [BANK_W-1:0]   prg_low;
        logic [BANK_W-1:0]   prg_high;
        logic                high_last;
        logic [BANK_W-1:0]   chr_win0;
        logic [BANK_W-1:0]   chr_win1;
        logic                ram_off;
        logic [1:0]          ram_bank;
        logic [1:0]          mirror;
    } t_map_state;

endpackage

// ----- hdl/serial_bank_switch_mapper.sv -----
// top level of the serial bank switch mapper
// Translates one CPU or PPU bus word per clock into a target memory and a byte offset,
// and shifts mapper register writes at 0x8000-0xFFFF into the five-write serial load
// register. Throughput is one word per cycle while the result is not stalled; words
// pass the input register, then the result register, with state update and translation
// done by the single level of logic between them. Configuration registers (board kind,
// PRG and CHR bank masks, CHR RAM flag) are to be written through the plain write port
// only while no word is in flight; the block does not enforce this. A stalled result
// holds; the input side keeps taking words until the input register is also full.
module serial_bank_switch_mapper (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration port
    input  logic        i_cfg_wen,
    input  logic [1:0]  i_cfg_idx,
    input  logic [4:0]  i_cfg_data,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_opcode,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_data_byte,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_target,
    output logic [18:0] o_phys_addr,
    output logic        o_store_enable,
    output logic [7:0]  o_open_value,
    output logic [1:0]  o_mirror_mode,
    output logic [1:0]  o_ram_bank
);

    smap_pkg::t_map_cfg   r_cfg;
    logic                 r_s1_valid;
    smap_pkg::t_item      r_s1_item;
    logic                 r_out_valid;
    smap_pkg::t_target    r_target;
    logic [18:0]          r_phys;
    logic                 r_store;
    logic [7:0]           r_open;
    logic [1:0]           r_mirror;
    logic [1:0]           r_ram_bank;

    logic                 advance;
    smap_pkg::t_map_state st_cur;
    smap_pkg::t_map_state st_nxt;
    smap_pkg::t_target    x_target;
    logic [18:0]          x_phys;
    logic                 x_store;
    logic [7:0]           x_open;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.board      <= smap_pkg::BOARD_GENERIC;
            r_cfg.prg_mask   <= 5'd15;
            r_cfg.chr_mask   <= 5'd31;
            r_cfg.chr_is_ram <= 1'b0;
        end else if (i_cfg_wen) begin
            unique case (smap_pkg::t_cfg_idx'(i_cfg_idx))
                smap_pkg::CFG_BOARD_KIND: r_cfg.board      <= smap_pkg::t_board'(i_cfg_data[1:0]);
                smap_pkg::CFG_PRG_MASK:   r_cfg.prg_mask   <= i_cfg_data;
                smap_pkg::CFG_CHR_MASK:   r_cfg.chr_mask   <= i_cfg_data;
                smap_pkg::CFG_CHR_IS_RAM: r_cfg.chr_is_ram <= i_cfg_data[0];
            endcase
        end
    end

    // handshake: input stage moves on when the result register is free or being taken
    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_s1_valid && !advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_s1_item.opcode  <= smap_pkg::t_opcode'(i_opcode);
            r_s1_item.address <= i_address;
            r_s1_item.data    <= i_data_byte;
        end
    end

    // mapper state and translation
    smap_state u_state (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance && r_s1_valid),
        .i_item  (r_s1_item),
        .i_cfg   (r_cfg),
        .o_cur   (st_cur),
        .o_nxt   (st_nxt)
    );

    smap_xlate u_xlate (
        .i_item   (r_s1_item),
        .i_st     (st_cur),
        .i_cfg    (r_cfg),
        .o_target (x_target),
        .o_phys   (x_phys),
        .o_store  (x_store),
        .o_open   (x_open)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_s1_valid) begin
            r_target   <= x_target;
            r_phys     <= x_phys;
            r_store    <= x_store;
            r_open     <= x_open;
            r_mirror   <= st_nxt.mirror;
            r_ram_bank <= st_nxt.ram_bank;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_target       = r_target;
    assign o_phys_addr    = r_phys;
    assign o_store_enable = r_store;
    assign o_open_value   = r_open;
    assign o_mirror_mode  = r_mirror;
    assign o_ram_bank     = r_ram_bank;

endmodule

// ----- hdl/smap_state.sv -----
// mapper register file: serial load register, mode bits and bank selections
module smap_state (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  smap_pkg::t_item      i_item,
    input  smap_pkg::t_map_cfg   i_cfg,
    output smap_pkg::t_map_state o_cur,
    output smap_pkg::t_map_state o_nxt
);

    smap_pkg::t_map_state r_st;
    smap_pkg::t_map_state n_st;

    logic [smap_pkg::BANK_W-1:0] shifted;
    logic                        map_write;
    logic                        win_sel;
    logic                        four_k;
    logic [3:0]                  hi_low;

    assign shifted   = {i_item.data[0], r_st.shift[smap_pkg::BANK_W-1:1]};
    assign map_write = i_step && (i_item.opcode == smap_pkg::OP_CPU_WR)
                       && i_item.address[smap_pkg::ADDR_W-1];
    assign win_sel   = i_item.address[14];
    assign four_k    = r_st.chr_mode;
    assign hi_low    = r_st.high_last ? smap_pkg::LAST_BANK_LOW : r_st.prg_high[3:0];

    // next state on a word that writes the mapper registers
    always_comb begin
        n_st = r_st;
        if (map_write) begin
            if (i_item.data[smap_pkg::DATA_W-1]) begin
                n_st.shift    = smap_pkg::SHIFT_EMPTY;
                n_st.prg_mode = smap_pkg::PRG_MODE_FIX_LAST;
            end else if (!r_st.shift[0]) begin
                n_st.shift = shifted;
            end else begin
                n_st.shift = smap_pkg::SHIFT_EMPTY;
                unique case (smap_pkg::t_load_sel'(i_item.address[14:13]))
                    smap_pkg::SEL_CONTROL: begin
                        n_st.prg_mode = shifted[3:2];
                        n_st.chr_mode = shifted[4];
                        if (shifted[1:0] == smap_pkg::CTL_MIR_HORZ) begin
                            n_st.mirror = smap_pkg::MIR_HORZ;
                        end else if (shifted[1:0] == smap_pkg::CTL_MIR_VERT) begin
                            n_st.mirror = smap_pkg::MIR_VERT;
                        end
                    end
                    smap_pkg::SEL_PRG: begin
                        priority if (r_st.prg_mode == smap_pkg::PRG_MODE_32K_A
                                     || r_st.prg_mode == smap_pkg::PRG_MODE_32K_B) begin
                            n_st.prg_low   = {1'b0, shifted[3:1], 1'b0};
                            n_st.prg_high  = {1'b0, shifted[3:1], 1'b1};
                            n_st.high_last = 1'b0;
                        end else if (r_st.prg_mode == smap_pkg::PRG_MODE_FIX_0) begin
                            n_st.prg_low   = '0;
                            n_st.prg_high  = {1'b0, shifted[3:0]};
                            n_st.high_last = 1'b0;
                        end else begin
                            n_st.prg_low   = {1'b0, shifted[3:0]};
                            n_st.high_last = 1'b1;
                        end
                    end
                    smap_pkg::SEL_CHR0, smap_pkg::SEL_CHR1: begin
                        unique case (i_cfg.board)
                            smap_pkg::BOARD_RAM_OFF: begin
                                if (!win_sel || four_k) begin
                                    if (four_k) begin
                                        if (win_sel) n_st.chr_win1 = {4'b0, shifted[0]};
                                        else         n_st.chr_win0 = {4'b0, shifted[0]};
                                    end
                                    n_st.ram_off = shifted[4];
                                end
                            end
                            smap_pkg::BOARD_OUTER_PRG: begin
                                if (!win_sel || four_k) begin
                                    if (four_k) begin
                                        if (win_sel) n_st.chr_win1 = {4'b0, shifted[0]};
                                        else         n_st.chr_win0 = {4'b0, shifted[0]};
                                    end
                                    // outer 256 KB bit goes to both windows
                                    n_st.ram_bank  = shifted[3:2];
                                    n_st.prg_low   = {shifted[4], r_st.prg_low[3:0]};
                                    n_st.prg_high  = {shifted[4], hi_low};
                                    n_st.high_last = 1'b0;
                                end
                            end
                            smap_pkg::BOARD_GENERIC, smap_pkg::BOARD_BIG_CHR: begin
                                if (four_k) begin
                                    if (win_sel) n_st.chr_win1 = shifted;
                                    else         n_st.chr_win0 = shifted;
                                end else if (!win_sel) begin
                                    n_st.chr_win0 = {shifted[4:1], 1'b0};
                                    n_st.chr_win1 = {shifted[4:1], 1'b1};
                                end
                            end
                        endcase
                    end
                endcase
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.shift     <= smap_pkg::SHIFT_EMPTY;
            r_st.prg_mode  <= smap_pkg::PRG_MODE_FIX_LAST;
            r_st.chr_mode  <= 1'b0;
            r_st.prg_low   <= '0;
            r_st.prg_high  <= '0;
            r_st.high_last <= 1'b1;
            r_st.chr_win0  <= '0;
            r_st.chr_win1  <= smap_pkg::BANK_W'(1);
            r_st.ram_off   <= 1'b0;
            r_st.ram_bank  <= '0;
            r_st.mirror    <= smap_pkg::MIR_HEADER;
        end else begin
            r_st <= n_st;
        end
    end

    assign o_cur = r_st;
    assign o_nxt = n_st;

endmodule

// ----- hdl/smap_xlate.sv -----
// address translation of one bus access to a target memory and offset
module smap_xlate (
    input  smap_pkg::t_item                    i_item,
    input  smap_pkg::t_map_state               i_st,
    input  smap_pkg::t_map_cfg                 i_cfg,
    output smap_pkg::t_target                  o_target,
    output logic [smap_pkg::PHYS_W-1:0]        o_phys,
    output logic                               o_store,
    output logic [smap_pkg::DATA_W-1:0]        o_open
);

    logic                        ppu;
    logic                        wr;
    logic [smap_pkg::BANK_W-1:0] prg_bank;
    logic [smap_pkg::BANK_W-1:0] chr_bank;

    assign ppu = i_item.opcode[1];
    assign wr  = i_item.opcode[0];

    // bank lookup for the two windows
    always_comb begin
        if (!i_item.address[smap_pkg::PRG_WINDOW_BITS]) begin
            prg_bank = i_st.prg_low & i_cfg.prg_mask;
        end else if (i_st.high_last) begin
            prg_bank = i_cfg.prg_mask;
        end else begin
            prg_bank = i_st.prg_high & i_cfg.prg_mask;
        end
        chr_bank = (i_item.address[smap_pkg::CHR_WINDOW_BITS] ? i_st.chr_win1 : i_st.chr_win0)
                   & i_cfg.chr_mask;
    end

    // target decode
    always_comb begin
        o_target = smap_pkg::TGT_NONE;
        o_phys   = '0;
        o_store  = 1'b0;
        if (!ppu) begin
            if (i_item.address[15:13] == 3'b011) begin
                if (!i_st.ram_off) begin
                    o_target = smap_pkg::TGT_PRG_RAM;
                    o_phys   = smap_pkg::PHYS_W'(i_item.address[12:0]);
                    o_store  = wr;
                end
            end else if (i_item.address[15] && !wr) begin
                o_target = smap_pkg::TGT_PRG_ROM;
                o_phys   = {prg_bank, i_item.address[smap_pkg::PRG_WINDOW_BITS-1:0]};
            end
        end else if (i_item.address[15:13] == 3'b000) begin
            if (i_cfg.chr_is_ram) begin
                o_target = smap_pkg::TGT_CHR_RAM;
                o_phys   = smap_pkg::PHYS_W'(i_item.address[12:0]);
                o_store  = wr;
            end else if (!wr) begin
                o_target = smap_pkg::TGT_CHR_ROM;
                o_phys   = {2'b00, chr_bank, i_item.address[smap_pkg::CHR_WINDOW_BITS-1:0]};
            end
        end
        o_open = (o_target == smap_pkg::TGT_NONE && ppu) ? smap_pkg::OPEN_PPU
                                                          : smap_pkg::OPEN_CPU;
    end

endmodule

// ----- hdl/smap_checker.sv -----
// port-level checks for the serial bank switch mapper, bound to the top level
module smap_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [2:0]  o_target,
    input logic [18:0] o_phys_addr,
    input logic        o_store_enable,
    input logic [7:0]  o_open_value
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_target)
            && $stable(o_phys_addr) && $stable(o_store_enable))
        else $error("stalled result word changed");

    // input side only stalls behind a full, stalled result register
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled while result register free");

    // nothing stored without a target memory
    a_no_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_target == smap_pkg::TGT_NONE |-> !o_store_enable)
        else $error("store with no target");

    // open bus value only when nothing is targeted
    a_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_target != smap_pkg::TGT_NONE |-> o_open_value == smap_pkg::OPEN_CPU)
        else $error("open bus value on a mapped access");

    // ram offsets stay within one 8 KB window
    a_ram_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_target == smap_pkg::TGT_PRG_RAM
            || o_target == smap_pkg::TGT_CHR_RAM) |-> o_phys_addr[18:13] == 6'd0)
        else $error("ram offset out of window");

endmodule

bind serial_bank_switch_mapper smap_checker u_smap_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_target       (o_target),
    .o_phys_addr    (o_phys_addr),
    .o_store_enable (o_store_enable),
    .o_open_value   (o_open_value)
);

// ----- bench/testbench.sv -----
// self-checking testbench for the serial bank switch mapper
module testbench;
    import smap_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASES       = 8;
    localparam int PHASE_WORDS  = 96;
    localparam int PRINT_CAP    = 30;

    // one translated access as it leaves the block
    typedef struct packed {
        t_target             target;
        logic [PHYS_W-1:0]   phys;
        logic                store;
        logic [DATA_W-1:0]   open_val;
        logic [1:0]          mirror;
        logic [1:0]          ram_bank;
    } t_access_word;

    // one line of the directed stimulus table
    typedef struct {
        bit                  is_reg;
        t_cfg_idx            reg_idx;
        logic [CFG_W-1:0]    reg_val;
        t_opcode             op;
        logic [ADDR_W-1:0]   addr;
        logic [DATA_W-1:0]   data;
        bit                  typed;
        t_access_word        want;
    } t_plan_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_wen;
    logic [1:0]        i_cfg_idx;
    logic [4:0]        i_cfg_data;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [1:0]        i_opcode;
    logic [15:0]       i_address;
    logic [7:0]        i_data_byte;
    logic              o_out_valid;
    logic              i_out_stall;
    logic [2:0]        o_target;
    logic [18:0]       o_phys_addr;
    logic              o_store_enable;
    logic [7:0]        o_open_value;
    logic [1:0]        o_mirror_mode;
    logic [1:0]        o_ram_bank;

    serial_bank_switch_mapper dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wen      (i_cfg_wen),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_opcode       (i_opcode),
        .i_address      (i_address),
        .i_data_byte    (i_data_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_target       (o_target),
        .o_phys_addr    (o_phys_addr),
        .o_store_enable (o_store_enable),
        .o_open_value   (o_open_value),
        .o_mirror_mode  (o_mirror_mode),
        .o_ram_bank     (o_ram_bank)
    );

    always #5 i_clk = ~i_clk;

    // mapper model state and board settings
    t_map_state     map_regs;
    t_map_cfg       board_cfg;
    t_access_word   expected_words[$];
    t_plan_row      plan[$];

    int  words_sent;
    int  words_checked;
    int  mismatches;
    int  reg_writes;
    int  rx_hold;
    int  cycles;
    bit  quiet;

    // translate one access and advance the mapper model
    function automatic t_access_word map_access(t_opcode op, logic [15:0] addr, logic [7:0] d);
        t_access_word r;
        logic ppu, wr, fifth, four, w;
        logic [4:0] v, bank, hi;
        ppu = op[1];
        wr  = op[0];
        r   = '0;
        if (!ppu) begin
            if (addr >= 16'h6000 && addr < 16'h8000) begin
                if (!map_regs.ram_off) begin
                    r.target = TGT_PRG_RAM;
                    r.phys   = PHYS_W'(addr - 16'h6000);
                    r.store  = wr;
                end
            end else if (addr[15] && wr) begin
                // serial load register
                if (d[7]) begin
                    map_regs.shift    = SHIFT_EMPTY;
                    map_regs.prg_mode = PRG_MODE_FIX_LAST;
                end else begin
                    fifth = map_regs.shift[0];
                    v = {d[0], map_regs.shift[4:1]};
                    map_regs.shift = v;
                    if (fifth) begin
                        four = map_regs.chr_mode;
                        w = (t_load_sel'(addr[14:13]) == SEL_CHR1);
                        case (t_load_sel'(addr[14:13]))
                            SEL_CONTROL: begin
                                map_regs.prg_mode = v[3:2];
                                map_regs.chr_mode = v[4];
                                if (v[1:0] == CTL_MIR_HORZ)
                                    map_regs.mirror = MIR_HORZ;
                                else if (v[1:0] == CTL_MIR_VERT)
                                    map_regs.mirror = MIR_VERT;
                            end
                            SEL_PRG: begin
                                if (map_regs.prg_mode == PRG_MODE_32K_A ||
                                        map_regs.prg_mode == PRG_MODE_32K_B) begin
                                    map_regs.prg_low   = {1'b0, v[3:1], 1'b0};
                                    map_regs.prg_high  = {1'b0, v[3:1], 1'b1};
                                    map_regs.high_last = 1'b0;
                                end else if (map_regs.prg_mode == PRG_MODE_FIX_0) begin
                                    map_regs.prg_low   = '0;
                                    map_regs.prg_high  = {1'b0, v[3:0]};
                                    map_regs.high_last = 1'b0;
                                end else begin
                                    map_regs.prg_low   = {1'b0, v[3:0]};
                                    map_regs.high_last = 1'b1;
                                end
                            end
                            default: begin
                                // chr bank registers, board variants reuse the bits
                                if (board_cfg.board == BOARD_RAM_OFF ||
                                        board_cfg.board == BOARD_OUTER_PRG) begin
                                    if (!w || four) begin
                                        if (four && w)
                                            map_regs.chr_win1 = {4'b0, v[0]};
                                        else if (four)
                                            map_regs.chr_win0 = {4'b0, v[0]};
                                        if (board_cfg.board == BOARD_RAM_OFF) begin
                                            map_regs.ram_off = v[4];
                                        end else begin
                                            hi = map_regs.high_last ? {1'b0, LAST_BANK_LOW}
                                                                    : map_regs.prg_high;
                                            map_regs.ram_bank  = v[3:2];
                                            map_regs.prg_low   = {v[4], map_regs.prg_low[3:0]};
                                            map_regs.prg_high  = {v[4], hi[3:0]};
                                            map_regs.high_last = 1'b0;
                                        end
                                    end
                                end else if (four) begin
                                    if (w)
                                        map_regs.chr_win1 = v;
                                    else
                                        map_regs.chr_win0 = v;
                                end else if (!w) begin
                                    map_regs.chr_win0 = {v[4:1], 1'b0};
                                    map_regs.chr_win1 = {v[4:1], 1'b1};
                                end
                            end
                        endcase
                        map_regs.shift = SHIFT_EMPTY;
                    end
                end
            end else if (addr[15]) begin
                // prg rom read through the two 16 KB windows
                if (!addr[PRG_WINDOW_BITS])
                    bank = map_regs.prg_low;
                else
                    bank = map_regs.high_last ? board_cfg.prg_mask : map_regs.prg_high;
                bank = bank & board_cfg.prg_mask;
                r.target = TGT_PRG_ROM;
                r.phys   = {bank, addr[PRG_WINDOW_BITS-1:0]};
            end
        end else if (addr < 16'h2000) begin
            if (board_cfg.chr_is_ram) begin
                r.target = TGT_CHR_RAM;
                r.phys   = PHYS_W'(addr);
                r.store  = wr;
            end else if (!wr) begin
                bank = (addr[CHR_WINDOW_BITS] ? map_regs.chr_win1 : map_regs.chr_win0)
                       & board_cfg.chr_mask;
                r.target = TGT_CHR_ROM;
                r.phys   = PHYS_W'({bank, addr[CHR_WINDOW_BITS-1:0]});
            end
        end
        r.open_val = (r.target == TGT_NONE && ppu) ? OPEN_PPU : OPEN_CPU;
        r.mirror   = map_regs.mirror;
        r.ram_bank = map_regs.ram_bank;
        return r;
    endfunction

    // table rows
    function automatic t_plan_row word_row(t_opcode op, logic [15:0] a, logic [7:0] d);
        t_plan_row row;
        row.is_reg  = 1'b0;
        row.reg_idx = CFG_BOARD_KIND;
        row.reg_val = '0;
        row.op      = op;
        row.addr    = a;
        row.data    = d;
        row.typed   = 1'b0;
        row.want    = '0;
        return row;
    endfunction

    function automatic t_plan_row checked_row(t_opcode op, logic [15:0] a, logic [7:0] d,
                                              t_target tg, logic [18:0] pa, logic se,
                                              logic [7:0] ov, logic [1:0] mir);
        t_plan_row row;
        row = word_row(op, a, d);
        row.typed         = 1'b1;
        row.want.target   = tg;
        row.want.phys     = pa;
        row.want.store    = se;
        row.want.open_val = ov;
        row.want.mirror   = mir;
        row.want.ram_bank = 2'd0;
        return row;
    endfunction

    function automatic t_plan_row reg_row(t_cfg_idx idx, logic [4:0] val);
        t_plan_row row;
        row.is_reg  = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        row.op      = OP_CPU_RD;
        row.addr    = '0;
        row.data    = '0;
        row.typed   = 1'b0;
        row.want    = '0;
        return row;
    endfunction

    // mismatch reporting
    task automatic report(string what, int unsigned got, int unsigned want);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("mismatch on word %0d: %s got %0h want %0h", words_checked, what, got, want);
    endtask

    // present one word on the input channel and record its expected translation
    task automatic send_word(t_opcode op, logic [15:0] addr, logic [7:0] data,
                             bit typed, t_access_word want);
        int gap;
        t_access_word model;
        gap = quiet ? 0 : $urandom_range(0, 8);
        @(negedge i_clk);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_opcode    <= op;
        i_address   <= addr;
        i_data_byte <= data;
        do @(posedge i_clk); while (o_in_stall);
        model = map_access(op, addr, data);
        expected_words.push_back(typed ? want : model);
        words_sent++;
    endtask

    // register write once every word in flight has come out
    task automatic write_reg(t_cfg_idx idx, logic [4:0] val);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_words.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_wen  <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_wen <= 1'b0;
        case (idx)
            CFG_BOARD_KIND: board_cfg.board      = t_board'(val[1:0]);
            CFG_PRG_MASK:   board_cfg.prg_mask   = val;
            CFG_CHR_MASK:   board_cfg.chr_mask   = val;
            default:        board_cfg.chr_is_ram = val[0];
        endcase
        reg_writes++;
    endtask

    // any access; inside a serial load no mapper register write is sent
    task automatic send_stray(bit in_seq);
        t_opcode op;
        logic [15:0] a;
        op = t_opcode'($urandom_range(0, 3));
        case ($urandom_range(0, 3))
            0:       a = 16'($urandom);
            1:       a = 16'h6000 | 16'($urandom_range(0, 16'h1FFF));
            2:       a = 16'h8000 | 16'($urandom_range(0, 16'h7FFF));
            default: a = 16'($urandom_range(0, 16'h1FFF));
        endcase
        if (in_seq && op == OP_CPU_WR && a[15])
            op = OP_CPU_RD;
        send_word(op, a, 8'($urandom), 1'b0, '0);
    endtask

    // mostly complete serial loads with random content, some cut short, plus stray accesses
    task automatic random_traffic(int count);
        int sent, cut;
        logic [4:0] v;
        logic [1:0] sel;
        logic [15:0] a;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 63) == 0)
                quiet = !quiet;
            if ($urandom_range(0, 9) < 5) begin
                v   = 5'($urandom);
                sel = 2'($urandom);
                cut = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4) : 5;
                for (int k = 0; k < 5; k++) begin
                    if ($urandom_range(0, 3) == 0) begin
                        send_stray(1'b1);
                        sent++;
                    end
                    a = {1'b1, (k == 4) ? sel : 2'($urandom), 13'($urandom)};
                    if (k == cut) begin
                        send_word(OP_CPU_WR, a, 8'h80 | 8'($urandom), 1'b0, '0);
                        sent++;
                        break;
                    end
                    send_word(OP_CPU_WR, a, {1'b0, 6'($urandom), v[k]}, 1'b0, '0);
                    sent++;
                end
            end else begin
                send_stray(1'b0);
                sent++;
            end
        end
    endtask

    // result side: random stall per word, compare against the oldest expectation
    always @(posedge i_clk) begin : rx_side
        t_access_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_words.size() == 0) begin
                report("word with no access pending", o_target, 0);
            end else begin
                want = expected_words.pop_front();
                if (o_target != want.target)
                    report("target", o_target, want.target);
                if (o_phys_addr != want.phys)
                    report("phys_addr", o_phys_addr, want.phys);
                if (o_store_enable != want.store)
                    report("store_enable", o_store_enable, want.store);
                if (o_open_value != want.open_val)
                    report("open_value", o_open_value, want.open_val);
                if (o_mirror_mode != want.mirror)
                    report("mirror_mode", o_mirror_mode, want.mirror);
                if (o_ram_bank != want.ram_bank)
                    report("ram_bank", o_ram_bank, want.ram_bank);
            end
            words_checked++;
            rx_hold = quiet ? 0 : $urandom_range(0, 8);
        end else if (o_out_valid && rx_hold != 0) begin
            rx_hold--;
        end
    end

    always @(negedge i_clk)
        i_out_stall <= (rx_hold != 0);

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // stimulus
    initial begin
        logic [4:0] pm, cm;
        i_rst_n     <= 1'b0;
        i_cfg_wen   <= 1'b0;
        i_cfg_idx   <= CFG_BOARD_KIND;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_opcode    <= OP_CPU_RD;
        i_address   <= '0;
        i_data_byte <= '0;
        quiet         = 1'b0;
        rx_hold       = 0;
        cycles        = 0;
        words_sent    = 0;
        words_checked = 0;
        mismatches    = 0;
        reg_writes    = 0;

        // model state after reset
        board_cfg.board      = BOARD_GENERIC;
        board_cfg.prg_mask   = 5'd15;
        board_cfg.chr_mask   = 5'd31;
        board_cfg.chr_is_ram = 1'b0;
        map_regs.shift       = SHIFT_EMPTY;
        map_regs.prg_mode    = PRG_MODE_FIX_LAST;
        map_regs.chr_mode    = 1'b0;
        map_regs.prg_low     = '0;
        map_regs.prg_high    = '0;
        map_regs.high_last   = 1'b1;
        map_regs.chr_win0    = 5'd0;
        map_regs.chr_win1    = 5'd1;
        map_regs.ram_off     = 1'b0;
        map_regs.ram_bank    = '0;
        map_regs.mirror      = MIR_HEADER;

        // directed table: reset translation, extremes, then loads that change the map
        plan.push_back(checked_row(OP_CPU_RD, 16'h0000, 8'h00, TGT_NONE, 19'h0, 1'b0,
                                   OPEN_CPU, MIR_HEADER));
        plan.push_back(checked_row(OP_CPU_WR, 16'h5FFF, 8'hFF, TGT_NONE, 19'h0, 1'b0,
                                   OPEN_CPU, MIR_HEADER));
        plan.push_back(checked_row(OP_CPU_WR, 16'h6000, 8'hAB, TGT_PRG_RAM, 19'h0, 1'b1,
                                   OPEN_CPU, MIR_HEADER));
        plan.push_back(checked_row(OP_CPU_RD, 16'h8000, 8'h00, TGT_PRG_ROM, 19'h0, 1'b0,
                                   OPEN_CPU, MIR_HEADER));
        plan.push_back(checked_row(OP_CPU_RD, 16'hFFFF, 8'h00, TGT_PRG_ROM, 19'h3FFFF, 1'b0,
                                   OPEN_CPU, MIR_HEADER));
        plan.push_back(checked_row(OP_PPU_RD, 16'h1FFF, 8'h00, TGT_CHR_ROM, 19'h01FFF, 1'b0,
                                   OPEN_CPU, MIR_HEADER));
        plan.push_back(checked_row(OP_PPU_WR, 16'h0000, 8'h55, TGT_NONE, 19'h0, 1'b0,
                                   OPEN_PPU, MIR_HEADER));
        plan.push_back(checked_row(OP_PPU_RD, 16'hFFFF, 8'h00, TGT_NONE, 19'h0, 1'b0,
                                   OPEN_PPU, MIR_HEADER));
        plan.push_back(checked_row(OP_CPU_WR, 16'hFFFF, 8'h80, TGT_NONE, 19'h0, 1'b0,
                                   OPEN_CPU, MIR_HEADER));
        // control load: horizontal mirroring, 32 KB prg mode, 4 KB chr mode
        plan.push_back(word_row(OP_CPU_WR, 16'h8000, 8'h7F));
        plan.push_back(word_row(OP_CPU_WR, 16'h8000, 8'h7F));
        plan.push_back(word_row(OP_CPU_WR, 16'h8000, 8'h7E));
        plan.push_back(word_row(OP_CPU_WR, 16'h8000, 8'h7E));
        plan.push_back(checked_row(OP_CPU_WR, 16'h9FFF, 8'h7F, TGT_NONE, 19'h0, 1'b0,
                                   OPEN_CPU, MIR_HORZ));
        // prg bank load while in 32 KB mode
        plan.push_back(word_row(OP_CPU_WR, 16'hE000, 8'h01));
        plan.push_back(word_row(OP_CPU_WR, 16'hF000, 8'h00));
        plan.push_back(word_row(OP_CPU_WR, 16'hE5A5, 8'h01));
        plan.push_back(word_row(OP_CPU_WR, 16'h8000, 8'h00));
        plan.push_back(word_row(OP_CPU_WR, 16'hFFFF, 8'h00));
        plan.push_back(word_row(OP_CPU_RD, 16'hC123, 8'h00));
        // load broken off by a reset write
        plan.push_back(word_row(OP_CPU_WR, 16'hA000, 8'h01));
        plan.push_back(checked_row(OP_CPU_WR, 16'h8000, 8'h80, TGT_NONE, 19'h0, 1'b0,
                                   OPEN_CPU, MIR_HORZ));
        // ram-disable board: chr bank 0 load with bit 4 set switches prg ram off
        plan.push_back(reg_row(CFG_BOARD_KIND, 5'(BOARD_RAM_OFF)));
        plan.push_back(word_row(OP_CPU_WR, 16'hA000, 8'h00));
        plan.push_back(word_row(OP_CPU_WR, 16'hA000, 8'h00));
        plan.push_back(word_row(OP_CPU_WR, 16'hA000, 8'h00));
        plan.push_back(word_row(OP_CPU_WR, 16'hA000, 8'h00));
        plan.push_back(word_row(OP_CPU_WR, 16'hBFFF, 8'h01));
        plan.push_back(checked_row(OP_CPU_RD, 16'h6000, 8'h00, TGT_NONE, 19'h0, 1'b0,
                                   OPEN_CPU, MIR_HORZ));

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[n]) begin
            if (plan[n].is_reg)
                write_reg(plan[n].reg_idx, plan[n].reg_val);
            else
                send_word(plan[n].op, plan[n].addr, plan[n].data, plan[n].typed, plan[n].want);
        end

        // random phases over board kinds and mask extremes
        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase == 0 || phase == 3)
                pm = 5'd31;
            else if (phase == 1)
                pm = 5'd0;
            else if (phase == 6)
                pm = 5'($urandom);
            else
                pm = 5'((1 << $urandom_range(1, 5)) - 1);
            if (phase == 0)
                cm = 5'd31;
            else if (phase == 1)
                cm = 5'd0;
            else
                cm = 5'((1 << $urandom_range(1, 5)) - 1);
            write_reg(CFG_BOARD_KIND, 5'(phase[1:0]));
            write_reg(CFG_PRG_MASK, pm);
            write_reg(CFG_CHR_MASK, cm);
            write_reg(CFG_CHR_IS_RAM, (phase == 4 || phase == 5) ? 5'd1 :
                                      (phase == 7) ? 5'($urandom_range(0, 1)) : 5'd0);
            random_traffic(PHASE_WORDS);
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_words.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("bus accesses sent %0d, translations checked %0d, register writes %0d",
                 words_sent, words_checked, reg_writes);
        $display("covered all four board kinds, mask extremes, chr ram and rom, %0d mismatches",
                 mismatches);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/smap_pkg.sv
hdl/smap_state.sv
hdl/smap_xlate.sv
hdl/serial_bank_switch_mapper.sv
hdl/smap_checker.sv
bench/testbench.sv
